// File: hdl/playfair_digraph_cipher_macros.svh
// assertion helpers for the playfair digraph cipher
`ifndef PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH

// same-cycle implication, checked out of reset
`define PF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("playfair cipher assertion failed");

// next-cycle implication, checked out of reset
`define PF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("playfair cipher assertion failed");

`endif

// File: hdl/pf_pkg.sv
package pf_pkg;

  localparam int GridSide    = 5;
  localparam int CellCount   = GridSide * GridSide;
  localparam int LetterCount = 26;

  // row = (pos * RowRecip) >> RowShift, exact for pos 0..24
  localparam int RowRecip = 13;
  localparam int RowShift = 6;

  typedef logic [4:0] letter_t;
  typedef logic [4:0] cell_t;
  typedef logic [2:0] coord_t;

  localparam letter_t LetterI = 5'd8;
  localparam letter_t LetterJ = 5'd9;
  localparam letter_t LetterX = 5'd23;
  localparam letter_t LetterZ = 5'd25;

  localparam logic [1:0] ActAddKey = 2'd0;
  localparam logic [1:0] ActFinish = 2'd1;
  localparam logic [1:0] ActCipher = 2'd2;

  typedef struct packed {
    logic    en;
    letter_t letter;
  } place_req_t;

  typedef struct packed {
    logic    en;
    letter_t letter_a;
    letter_t letter_b;
  } pos_req_t;

  typedef struct packed {
    logic  en;
    cell_t idx_a;
    cell_t idx_b;
  } grid_req_t;

  function automatic letter_t fold_j(letter_t l);
    return (l == LetterJ) ? LetterI : l;
  endfunction

  // out-of-range codes saturate to z, then j folds onto i
  function automatic letter_t cipher_letter(letter_t raw);
    letter_t v;
    v = (raw > LetterZ) ? LetterZ : raw;
    return fold_j(v);
  endfunction

endpackage

// File: hdl/playfair_digraph_cipher.sv
// playfair digraph cipher engine
// input channel (in_valid_i / in_stall_o) carries one item per handshake:
//   add key letter - placed in the 5x5 table if new
//   finish key     - sweeps a..z (j skipped) into the free cells, busy until z
//   cipher a pair  - two position lookups, two table reads, one result item
// output channel (out_valid_o / out_stall_i) carries the substituted pair.
// a cipher item passes the position lookup, then the table read, then the
// output register; the next item is taken once the result sits in the output
// register, so pairs never overlap; the lookup and table read run in series.
// the user writes decrypt_mode through decrypt_mode_we_i only while the block
// is idle; the block does not enforce it. reset clears the table bookkeeping,
// the mode and the output valid flag; table contents are only meaningful once
// written. while the receiver stalls the result holds in the output register
// and a pending cipher item waits in its last stage, stalling the input side.
`include "playfair_digraph_cipher_macros.svh"

module playfair_digraph_cipher (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       decrypt_mode_we_i,
  input  logic       decrypt_mode_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  logic [4:0] first_letter_i,
  input  logic [4:0] second_letter_i,
  input  logic       second_present_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [4:0] out_first_o,
  output logic [4:0] out_second_o
);

  // sequencer states
  localparam logic [1:0] StIdle    = 2'd0;
  localparam logic [1:0] StFill    = 2'd1;
  localparam logic [1:0] StLookup  = 2'd2;
  localparam logic [1:0] StDeliver = 2'd3;

  logic [1:0]      state_q, state_d;
  pf_pkg::letter_t ltr_q, ltr_d;        // finish sweep letter
  logic            decrypt_q;
  logic            out_valid_q, out_valid_d;
  pf_pkg::letter_t out_first_q, out_second_q;

  logic               accept;
  logic               out_take;
  pf_pkg::place_req_t place_req;
  pf_pkg::pos_req_t   pos_req;
  pf_pkg::grid_req_t  grid_req;
  pf_pkg::cell_t      pos_a, pos_b;
  pf_pkg::cell_t      idx_a, idx_b;
  pf_pkg::letter_t    grid_a, grid_b;
  pf_pkg::cell_t      fill_count;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  // output register free or draining this cycle
  assign out_take   = !out_valid_q || !out_stall_i;

  // key placement: one letter per item, or one per cycle during the sweep
  always_comb begin
    place_req.en     = 1'b0;
    place_req.letter = first_letter_i;
    if (state_q == StFill) begin
      place_req.en     = (ltr_q != pf_pkg::LetterJ);
      place_req.letter = ltr_q;
    end else if (accept && (action_i == pf_pkg::ActAddKey)) begin
      place_req.en = 1'b1;
    end
  end

  // position lookups start at acceptance; odd tail pads with x
  assign pos_req.en       = accept && (action_i == pf_pkg::ActCipher);
  assign pos_req.letter_a = pf_pkg::cipher_letter(first_letter_i);
  assign pos_req.letter_b = second_present_i ? pf_pkg::cipher_letter(second_letter_i)
                                             : pf_pkg::LetterX;

  // table reads once positions are back
  assign grid_req.en    = (state_q == StLookup);
  assign grid_req.idx_a = idx_a;
  assign grid_req.idx_b = idx_b;

  pf_keystore u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .place_i      (place_req),
    .pos_req_i    (pos_req),
    .grid_req_i   (grid_req),
    .pos_a_o      (pos_a),
    .pos_b_o      (pos_b),
    .grid_a_o     (grid_a),
    .grid_b_o     (grid_b),
    .fill_count_o (fill_count)
  );

  // one lane per letter, each sees the other's position for the rule choice
  pf_lane u_lane_a (
    .pos_self_i  (pos_a),
    .pos_other_i (pos_b),
    .decrypt_i   (decrypt_q),
    .idx_o       (idx_a)
  );

  pf_lane u_lane_b (
    .pos_self_i  (pos_b),
    .pos_other_i (pos_a),
    .decrypt_i   (decrypt_q),
    .idx_o       (idx_b)
  );

  always_comb begin
    state_d     = state_q;
    ltr_d       = ltr_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (accept && (action_i == pf_pkg::ActFinish)) begin
          state_d = StFill;
          ltr_d   = '0;
        end else if (accept && (action_i == pf_pkg::ActCipher)) begin
          state_d = StLookup;
        end
      end
      StFill: begin
        if (ltr_q == pf_pkg::LetterZ) begin
          state_d = StIdle;
        end else begin
          ltr_d = ltr_q + 5'd1;
        end
      end
      StLookup: begin
        state_d = StDeliver;
      end
      StDeliver: begin
        // merge both lanes into the output register
        if (out_take) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ltr_q       <= '0;
      decrypt_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ltr_q       <= ltr_d;
      out_valid_q <= out_valid_d;
      if (decrypt_mode_we_i) begin
        decrypt_q <= decrypt_mode_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StDeliver) && out_take) begin
      out_first_q  <= grid_a;
      out_second_q <= grid_b;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_first_o  = out_first_q;
  assign out_second_o = out_second_q;

  // the table never holds more than its cell count
  `PF_ASSERT_NOW(a_fill_bound, clk_i, rst_ni, 1'b1, fill_count <= 5'(pf_pkg::CellCount))
  // the finish sweep always leaves a full table
  `PF_ASSERT_NEXT(a_sweep_full, clk_i, rst_ni,
    (state_q == StFill) && (ltr_q == pf_pkg::LetterZ), fill_count == 5'(pf_pkg::CellCount))
  // a cipher item goes straight to its lookup stage
  `PF_ASSERT_NEXT(a_cipher_start, clk_i, rst_ni,
    accept && (action_i == pf_pkg::ActCipher), state_q == StLookup)
  // a result leaving the last stage lands in the output register
  `PF_ASSERT_NEXT(a_deliver, clk_i, rst_ni,
    (state_q == StDeliver) && out_take, out_valid_q && (state_q == StIdle))

endmodule

// File: hdl/pf_keystore.sv
module pf_keystore (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pf_pkg::place_req_t place_i,
  input  pf_pkg::pos_req_t   pos_req_i,
  input  pf_pkg::grid_req_t  grid_req_i,
  output pf_pkg::cell_t      pos_a_o,
  output pf_pkg::cell_t      pos_b_o,
  output pf_pkg::letter_t    grid_a_o,
  output pf_pkg::letter_t    grid_b_o,
  output pf_pkg::cell_t      fill_count_o
);

  logic [pf_pkg::LetterCount-1:0] used_q, used_d;
  pf_pkg::cell_t                  fill_q, fill_d;

  pf_pkg::cell_t   pos_mem  [pf_pkg::LetterCount];
  pf_pkg::letter_t grid_mem [pf_pkg::CellCount];

  pf_pkg::cell_t   pos_rd_a_q, pos_rd_b_q;
  logic            used_a_q, used_b_q;
  pf_pkg::letter_t grid_rd_a_q, grid_rd_b_q;

  pf_pkg::letter_t place_letter;
  logic            in_range;
  logic            do_place;

  assign place_letter = pf_pkg::fold_j(place_i.letter);
  assign in_range     = place_i.letter < 5'(pf_pkg::LetterCount);
  assign do_place     = place_i.en && in_range && !used_q[place_letter]
                        && (fill_q < 5'(pf_pkg::CellCount));

  always_comb begin
    used_d = used_q;
    fill_d = fill_q;
    if (do_place) begin
      used_d[place_letter] = 1'b1;
      fill_d               = fill_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      fill_q <= '0;
    end else begin
      used_q <= used_d;
      fill_q <= fill_d;
    end
  end

  // table writes
  always_ff @(posedge clk_i) begin
    if (do_place) begin
      pos_mem[place_letter] <= fill_q;
      grid_mem[fill_q]      <= place_letter;
    end
  end

  // position lookups, both letters at once
  always_ff @(posedge clk_i) begin
    if (pos_req_i.en) begin
      pos_rd_a_q <= pos_mem[pos_req_i.letter_a];
      pos_rd_b_q <= pos_mem[pos_req_i.letter_b];
      used_a_q   <= used_q[pos_req_i.letter_a];
      used_b_q   <= used_q[pos_req_i.letter_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (grid_req_i.en) begin
      grid_rd_a_q <= grid_mem[grid_req_i.idx_a];
      grid_rd_b_q <= grid_mem[grid_req_i.idx_b];
    end
  end

  // a letter not yet placed sits at cell 0
  assign pos_a_o      = used_a_q ? pos_rd_a_q : '0;
  assign pos_b_o      = used_b_q ? pos_rd_b_q : '0;
  assign grid_a_o     = grid_rd_a_q;
  assign grid_b_o     = grid_rd_b_q;
  assign fill_count_o = fill_q;

endmodule

// File: hdl/pf_lane.sv
module pf_lane (
  input  pf_pkg::cell_t pos_self_i,
  input  pf_pkg::cell_t pos_other_i,
  input  logic          decrypt_i,
  output pf_pkg::cell_t idx_o
);

  logic [8:0]     prod_self, prod_other;
  pf_pkg::coord_t row_s, col_s, row_o, col_o;
  pf_pkg::coord_t row_t, col_t;
  logic [4:0]     row_s_x5, row_o_x5;

  function automatic pf_pkg::coord_t step(pf_pkg::coord_t c, logic dec);
    pf_pkg::coord_t r;
    if (dec) begin
      r = (c == 3'd0) ? 3'(pf_pkg::GridSide - 1) : c - 3'd1;
    end else begin
      r = (c == 3'(pf_pkg::GridSide - 1)) ? 3'd0 : c + 3'd1;
    end
    return r;
  endfunction

  assign prod_self  = 9'(pos_self_i) * 9'(pf_pkg::RowRecip);
  assign prod_other = 9'(pos_other_i) * 9'(pf_pkg::RowRecip);
  assign row_s      = 3'(prod_self >> pf_pkg::RowShift);
  assign row_o      = 3'(prod_other >> pf_pkg::RowShift);
  assign row_s_x5   = 5'(row_s) * 5'(pf_pkg::GridSide);
  assign row_o_x5   = 5'(row_o) * 5'(pf_pkg::GridSide);
  assign col_s      = 3'(pos_self_i - row_s_x5);
  assign col_o      = 3'(pos_other_i - row_o_x5);

  always_comb begin
    priority if (row_s == row_o) begin
      row_t = row_s;
      col_t = step(col_s, decrypt_i);
    end else if (col_s == col_o) begin
      row_t = step(row_s, decrypt_i);
      col_t = col_s;
    end else begin
      row_t = row_s;
      col_t = col_o;
    end
  end

  assign idx_o = 5'(row_t) * 5'(pf_pkg::GridSide) + 5'(col_t);

endmodule
